### hw/rtl/ctwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctwa_pkg
// Shared types and constants for the connection table with aging.
// ----------------------------------------------------------------------------
package ctwa_pkg;

    localparam int          SLOTS_DEFAULT     = 16;
    localparam logic [15:0] STALE_LIMIT_RESET = 16'd1000;

    // Command codes
    localparam logic [1:0] CMD_ADD       = 2'd0;
    localparam logic [1:0] CMD_ESTABLISH = 2'd1;
    localparam logic [1:0] CMD_PRUNE     = 2'd2;
    localparam logic [1:0] CMD_CLEAR     = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_MISS  = 2'd2;

    // One slot as stored in the table memory
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [15:0] id;
        logic [15:0] age;
        logic        is_new;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic busy;     // command in flight, hold off input
        logic rd;       // issue a table read this cycle
        logic proc;     // read data valid, process one slot
        logic finish;   // final update and result load this cycle
    } ctrl_t;

endpackage

### hw/rtl/connection_table_with_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_table_with_aging
// Connection slot table keyed by IPv4 address and port, with idle aging.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives exactly one result. Slot contents
// live in a single-port-read, single-port-write RAM; every command except
// clear walks all SLOTS entries, one read per cycle. Occupancy bits sit in
// flops and are cleared by reset and by the clear command. Add reuses the
// slot already holding the key, else the lowest free slot, else reports full.
// Establish zeroes the age of a matching slot. Prune adds elapsed_ms
// (saturating) to every live age and frees only the highest slot at or past
// stale_limit. stale_limit is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while idle, as the block does not enforce this. A
// finished result sits in an output register, so the next command is taken
// while that result still waits.
// ----------------------------------------------------------------------------
module connection_table_with_aging #(
    parameter int SLOTS = ctwa_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] ip_addr,
    input  logic [15:0] port,
    input  logic [15:0] conn_id,
    input  logic [15:0] elapsed_ms,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  slot,
    output logic [15:0] found_id,
    output logic        is_new,
    output logic        pruned,
    output logic [3:0]  pruned_slot,
    output logic [31:0] pruned_ip,
    output logic [15:0] pruned_port
);

    import ctwa_pkg::*;

    localparam int IW = $clog2(SLOTS);

    // ------------------------------------------------------------------
    // Handshake and sequencer
    // ------------------------------------------------------------------
    ctrl_t         ctrl;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] pidx;
    logic          in_fire;
    logic          out_free;
    logic          out_valid_reg;

    assign in_stall = ctrl.busy;
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    ctwa_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_fire),
        .start_clear (cmd == CMD_CLEAR),
        .out_free    (out_free),
        .ctrl        (ctrl),
        .rd_addr     (rd_addr),
        .proc_addr   (pidx)
    );

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [15:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= STALE_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Table memory and occupancy
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             ent;
    logic [SLOTS-1:0]   valid_reg;
    logic               ent_valid;

    ctwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctrl.rd),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign ent       = entry_t'(ram_rdata);
    assign ent_valid = valid_reg[pidx];

    // ------------------------------------------------------------------
    // Command latch and walk accumulators
    // ------------------------------------------------------------------
    logic [1:0]    cmd_reg;
    logic [31:0]   ip_reg;
    logic [15:0]   port_reg;
    logic [15:0]   cid_reg;
    logic [15:0]   ms_reg;

    logic          hit_reg;
    logic [IW-1:0] hit_slot_reg;
    logic [15:0]   hit_id_reg;
    logic          hit_new_reg;
    logic          free_reg;
    logic [IW-1:0] free_slot_reg;
    logic          vic_reg;
    logic [IW-1:0] vic_slot_reg;
    logic [31:0]   vic_ip_reg;
    logic [15:0]   vic_port_reg;

    logic          key_match;
    logic [16:0]   age_sum;
    logic [15:0]   age_new;
    logic          stale;
    entry_t        aged_ent;

    assign key_match = ent_valid && (ent.ip == ip_reg) && (ent.port == port_reg);
    assign age_sum   = {1'b0, ent.age} + {1'b0, ms_reg};
    assign age_new   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
    assign stale     = (age_new >= limit_reg);

    always_comb
    begin
        aged_ent     = ent;
        aged_ent.age = age_new;
    end

    // Latch the command on transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= cmd;
            ip_reg   <= ip_addr;
            port_reg <= port;
            cid_reg  <= conn_id;
            ms_reg   <= elapsed_ms;
        end
    end

    // Flags of the walk: first key match, lowest free slot, highest stale slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            vic_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            vic_reg  <= 1'b0;
        end
        else if (ctrl.proc)
        begin
            if (key_match && !hit_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (!ent_valid && !free_reg)
            begin
                free_reg <= 1'b1;
            end
            if (ent_valid && stale && (cmd_reg == CMD_PRUNE))
            begin
                vic_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.proc)
        begin
            if (key_match && !hit_reg)
            begin
                hit_slot_reg <= pidx;
                hit_id_reg   <= ent.id;
                hit_new_reg  <= ent.is_new;
            end
            if (!ent_valid && !free_reg)
            begin
                free_slot_reg <= pidx;
            end
            // later slots overwrite, so the highest stale slot wins
            if (ent_valid && stale)
            begin
                vic_slot_reg <= pidx;
                vic_ip_reg   <= ent.ip;
                vic_port_reg <= ent.port;
            end
        end
    end

    // ------------------------------------------------------------------
    // Write-back: aged entries during a prune walk, the new or refreshed
    // entry at finish. The walk writes the slot read in the cycle before, so
    // write and read never meet on one entry.
    // ------------------------------------------------------------------
    logic          add_ok;
    logic [IW-1:0] add_slot;

    assign add_ok   = hit_reg || free_reg;
    assign add_slot = hit_reg ? hit_slot_reg : free_slot_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pidx;
        ram_wdata = aged_ent;
        if (ctrl.proc && (cmd_reg == CMD_PRUNE) && ent_valid)
        begin
            ram_we = 1'b1;
        end
        if (ctrl.finish)
        begin
            case (cmd_reg)
                CMD_ADD:
                begin
                    ram_we    = add_ok;
                    ram_waddr = add_slot;
                    ram_wdata = '{ip: ip_reg, port: port_reg, id: cid_reg,
                                  age: 16'd0, is_new: 1'b1};
                end
                CMD_ESTABLISH:
                begin
                    ram_we    = hit_reg;
                    ram_waddr = hit_slot_reg;
                    ram_wdata = '{ip: ip_reg, port: port_reg, id: hit_id_reg,
                                  age: 16'd0, is_new: hit_new_reg};
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // Occupancy update at finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.finish)
        begin
            case (cmd_reg)
                CMD_ADD:
                begin
                    if (add_ok)
                    begin
                        valid_reg[add_slot] <= 1'b1;
                    end
                end
                CMD_PRUNE:
                begin
                    if (vic_reg)
                    begin
                        valid_reg[vic_slot_reg] <= 1'b0;
                    end
                end
                CMD_CLEAR:
                begin
                    valid_reg <= '0;
                end
                default:
                begin
                    valid_reg <= valid_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result assembly and output register
    // ------------------------------------------------------------------
    logic [IW+3:0] add_slot_ext;
    logic [IW+3:0] hit_slot_ext;
    logic [IW+3:0] vic_slot_ext;

    assign add_slot_ext = {4'd0, add_slot};
    assign hit_slot_ext = {4'd0, hit_slot_reg};
    assign vic_slot_ext = {4'd0, vic_slot_reg};

    logic [1:0]  status_next;
    logic [3:0]  slot_next;
    logic [15:0] found_id_next;
    logic        is_new_next;
    logic        pruned_next;
    logic [3:0]  pruned_slot_next;
    logic [31:0] pruned_ip_next;
    logic [15:0] pruned_port_next;

    always_comb
    begin
        status_next      = STATUS_OK;
        slot_next        = 4'd0;
        found_id_next    = 16'd0;
        is_new_next      = 1'b0;
        pruned_next      = 1'b0;
        pruned_slot_next = 4'd0;
        pruned_ip_next   = 32'd0;
        pruned_port_next = 16'd0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (add_ok)
                begin
                    slot_next     = add_slot_ext[3:0];
                    found_id_next = cid_reg;
                    is_new_next   = 1'b1;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            CMD_ESTABLISH:
            begin
                if (hit_reg)
                begin
                    slot_next     = hit_slot_ext[3:0];
                    found_id_next = hit_id_reg;
                    is_new_next   = hit_new_reg;
                end
                else
                begin
                    status_next = STATUS_MISS;
                end
            end
            CMD_PRUNE:
            begin
                if (vic_reg)
                begin
                    pruned_next      = 1'b1;
                    pruned_slot_next = vic_slot_ext[3:0];
                    pruned_ip_next   = vic_ip_reg;
                    pruned_port_next = vic_port_reg;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    logic [1:0]  status_reg;
    logic [3:0]  slot_reg;
    logic [15:0] found_id_reg;
    logic        is_new_reg;
    logic        pruned_reg;
    logic [3:0]  pruned_slot_reg;
    logic [31:0] pruned_ip_reg;
    logic [15:0] pruned_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            status_reg      <= status_next;
            slot_reg        <= slot_next;
            found_id_reg    <= found_id_next;
            is_new_reg      <= is_new_next;
            pruned_reg      <= pruned_next;
            pruned_slot_reg <= pruned_slot_next;
            pruned_ip_reg   <= pruned_ip_next;
            pruned_port_reg <= pruned_port_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign found_id    = found_id_reg;
    assign is_new      = is_new_reg;
    assign pruned      = pruned_reg;
    assign pruned_slot = pruned_slot_reg;
    assign pruned_ip   = pruned_ip_reg;
    assign pruned_port = pruned_port_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_transfer: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> in_stall
    ) else $error("command transfer did not start the sequencer");

    a_full_means_all_live: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ctrl.finish && (cmd_reg == CMD_ADD) && !add_ok) |-> (&valid_reg)
    ) else $error("table full reported with a free slot");

    a_add_sets_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ctrl.finish && (cmd_reg == CMD_ADD) && add_ok) |=> valid_reg[$past(add_slot)]
    ) else $error("added slot not marked live");

    a_prune_frees_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ctrl.finish && (cmd_reg == CMD_PRUNE) && vic_reg)
            |=> !valid_reg[$past(vic_slot_reg)]
    ) else $error("pruned slot still live");

    a_clear_empties: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ctrl.finish && (cmd_reg == CMD_CLEAR)) |=> (valid_reg == '0)
    ) else $error("clear left live slots");

endmodule

### hw/rtl/ctwa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctwa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ctwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/ctwa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctwa_seq
// Command sequencer: walks every slot once (clear skips the walk), then finishes the command.
// ----------------------------------------------------------------------------
module ctwa_seq #(
    parameter int SLOTS = ctwa_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     start_clear,
    input  logic                     out_free,
    output ctwa_pkg::ctrl_t          ctrl,
    output logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic [$clog2(SLOTS)-1:0] proc_addr
);

    import ctwa_pkg::*;

    localparam int             IW   = $clog2(SLOTS);
    localparam logic [IW-1:0]  LAST = IW'(SLOTS - 1);

    seq_state_t    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          pend_reg;
    logic [IW-1:0] pidx_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    state_next = start_clear ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (idx_reg == LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl.busy   = (state_reg != ST_IDLE);
        ctrl.rd     = (state_reg == ST_WALK);
        ctrl.proc   = pend_reg;
        ctrl.finish = (state_reg == ST_FINISH) && out_free;
    end

    assign rd_addr   = idx_reg;
    assign proc_addr = pidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            pidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= (state_reg == ST_WALK);
            pidx_reg  <= idx_reg;
        end
    end

endmodule

### bench/tb_connection_table_with_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_connection_table_with_aging
// Self-checking bench for the connection table with idle aging.
// ----------------------------------------------------------------------------
// A scripted opening covers the empty table, key extremes, rewriting an
// existing key, a full table, saturating ages, pruning at a zero and at the
// top limit, and clear. A long random run follows. It uses a small pool of
// keys so that lookups hit, rewrites happen and the table fills up. Every
// accepted command runs through a local model of the table. Each result
// transfer is compared field by field with the oldest prediction. Both
// channels idle in random bursts. One long receiver hold fills the block
// and stalls the command channel.
// ----------------------------------------------------------------------------
module tb_connection_table_with_aging;
    import ctwa_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int KEY_POOL     = 24;
    localparam int RANDOM_ITEMS = 830;
    localparam int QUIET_ITEMS  = 100;
    localparam int PHASE_ITEMS  = 120;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ip;
        logic [15:0] l4_port;
        logic [15:0] id;
        logic [15:0] ms;
    } conn_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [15:0] found_id;
        logic        is_new;
        logic        pruned;
        logic [3:0]  pruned_slot;
        logic [31:0] pruned_ip;
        logic [15:0] pruned_port;
    } conn_result_t;

    // One line of the opening script: either a limit write or a command,
    // with the answer written out where it is obvious.
    typedef struct {
        bit           is_cfg;
        logic [15:0]  cfg_val;
        conn_cmd_t    item;
        bit           typed;
        conn_result_t want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_CLEAR;
    logic [31:0] ip_addr = '0;
    logic [15:0] port = '0;
    logic [15:0] conn_id = '0;
    logic [15:0] elapsed_ms = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] found_id;
    logic        is_new;
    logic        pruned;
    logic [3:0]  pruned_slot;
    logic [31:0] pruned_ip;
    logic [15:0] pruned_port;

    // Local copy of the table and its limit
    logic        tbl_valid [SLOTS];
    logic [31:0] tbl_ip    [SLOTS];
    logic [15:0] tbl_port  [SLOTS];
    logic [15:0] tbl_id    [SLOTS];
    logic [15:0] tbl_age   [SLOTS];
    logic        tbl_new   [SLOTS];
    logic [15:0] limit_shadow;

    conn_result_t pending_results[$];
    script_row_t  opening_rows[$];
    logic [31:0]  pool_ip   [KEY_POOL];
    logic [15:0]  pool_port [KEY_POOL];

    int fail_count  = 0;
    int cycle_count = 0;
    int gap_pct     = 20;
    int stall_pct   = 20;
    bit quiet       = 1'b0;
    bit hold_request = 1'b0;
    int hold_left   = 0;
    int burst_left  = 0;

    connection_table_with_aging #(
        .SLOTS (SLOTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .ip_addr     (ip_addr),
        .port        (port),
        .conn_id     (conn_id),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot        (slot),
        .found_id    (found_id),
        .is_new      (is_new),
        .pruned      (pruned),
        .pruned_slot (pruned_slot),
        .pruned_ip   (pruned_ip),
        .pruned_port (pruned_port)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the handshake hangs
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic conn_result_t mk_result(logic [1:0] st, logic [3:0] sl,
                                               logic [15:0] fid, logic nw,
                                               logic pr, logic [3:0] psl,
                                               logic [31:0] pip, logic [15:0] ppt);
        conn_result_t r;
        r.status      = st;
        r.slot        = sl;
        r.found_id    = fid;
        r.is_new      = nw;
        r.pruned      = pr;
        r.pruned_slot = psl;
        r.pruned_ip   = pip;
        r.pruned_port = ppt;
        return r;
    endfunction

    function automatic conn_cmd_t mk_cmd(logic [1:0] op, logic [31:0] ip,
                                         logic [15:0] pt, logic [15:0] id,
                                         logic [15:0] ms);
        conn_cmd_t c;
        c.op      = op;
        c.ip      = ip;
        c.l4_port = pt;
        c.id      = id;
        c.ms      = ms;
        return c;
    endfunction

    // Index of the live slot holding the key, -1 when absent
    function automatic int slot_of_key(logic [31:0] ip, logic [15:0] pt);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && tbl_ip[i] == ip && tbl_port[i] == pt)
                return i;
        return -1;
    endfunction

    // Apply one command to the local table and return the result it gives
    function automatic conn_result_t apply_table_command(conn_cmd_t c);
        conn_result_t r;
        int           hit;
        int           victim;
        logic [16:0]  sum;
        r      = '0;
        victim = -1;
        case (c.op)
            CMD_ADD:
            begin
                hit = slot_of_key(c.ip, c.l4_port);
                if (hit < 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!tbl_valid[i] && hit < 0)
                            hit = i;
                end
                if (hit < 0)
                    r.status = STATUS_FULL;
                else
                begin
                    tbl_valid[hit] = 1'b1;
                    tbl_ip[hit]    = c.ip;
                    tbl_port[hit]  = c.l4_port;
                    tbl_id[hit]    = c.id;
                    tbl_age[hit]   = '0;
                    tbl_new[hit]   = 1'b1;
                    r.slot         = hit[3:0];
                    r.found_id     = c.id;
                    r.is_new       = 1'b1;
                end
            end
            CMD_ESTABLISH:
            begin
                hit = slot_of_key(c.ip, c.l4_port);
                if (hit < 0)
                    r.status = STATUS_MISS;
                else
                begin
                    tbl_age[hit] = '0;
                    r.slot       = hit[3:0];
                    r.found_id   = tbl_id[hit];
                    r.is_new     = tbl_new[hit];
                end
            end
            CMD_PRUNE:
            begin
                // Age every live slot, saturating, and keep the highest stale one
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        sum        = {1'b0, tbl_age[i]} + {1'b0, c.ms};
                        tbl_age[i] = sum[16] ? 16'hFFFF : sum[15:0];
                        if (tbl_age[i] >= limit_shadow)
                            victim = i;
                    end
                end
                if (victim >= 0)
                begin
                    tbl_valid[victim] = 1'b0;
                    r.pruned          = 1'b1;
                    r.pruned_slot     = victim[3:0];
                    r.pruned_ip       = tbl_ip[victim];
                    r.pruned_port     = tbl_port[victim];
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    tbl_valid[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want_v,
                                          logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    function automatic void check_result_transfer();
        conn_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result transfer with nothing expected, status %0d slot %0d",
                     $time, status, slot);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("slot", 32'(want.slot), 32'(slot));
        compare_field("found_id", 32'(want.found_id), 32'(found_id));
        compare_field("is_new", 32'(want.is_new), 32'(is_new));
        compare_field("pruned", 32'(want.pruned), 32'(pruned));
        compare_field("pruned_slot", 32'(want.pruned_slot), 32'(pruned_slot));
        compare_field("pruned_ip", want.pruned_ip, pruned_ip);
        compare_field("pruned_port", 32'(want.pruned_port), 32'(pruned_port));
    endfunction

    // Result side: check each transfer, then pick the stall for the next cycle.
    // A long hold requested by the stimulus wins over the random bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result_transfer();
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0 && !quiet)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                burst_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Present one command and hold it until the block takes it
    task automatic send_command(input conn_cmd_t c, input bit typed,
                                input conn_result_t want);
        conn_result_t pred;
        in_valid   <= 1'b1;
        cmd        <= c.op;
        ip_addr    <= c.ip;
        port       <= c.l4_port;
        conn_id    <= c.id;
        elapsed_ms <= c.ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = apply_table_command(c);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Drop valid for a random burst, unless in a stretch without idling
    task automatic maybe_idle(input bit allow);
        if (allow && !quiet && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Pause the command side until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_stale_limit(input logic [15:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        limit_shadow = v;
    endtask

    function automatic void add_row(conn_cmd_t c, bit typed, conn_result_t want);
        script_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.item    = c;
        r.typed   = typed;
        r.want    = want;
        opening_rows.push_back(r);
    endfunction

    function automatic void add_cfg_row(logic [15:0] v);
        script_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        r.item    = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        opening_rows.push_back(r);
    endfunction

    function automatic void build_opening();
        conn_result_t none;
        none = '0;
        // Empty table: lookup misses, prune frees nothing
        add_row(mk_cmd(CMD_ESTABLISH, 32'h0, 16'h0, 16'h0, 16'h0), 1,
                mk_result(STATUS_MISS, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'hFFFF), 1, none);
        // Key extremes, then a rewrite of an existing key in place
        add_row(mk_cmd(CMD_ADD, 32'h0, 16'h0, 16'h0, 16'h0), 1,
                mk_result(STATUS_OK, 0, 16'h0, 1, 0, 0, 0, 0));
        add_row(mk_cmd(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                mk_result(STATUS_OK, 1, 16'hFFFF, 1, 0, 0, 0, 0));
        add_row(mk_cmd(CMD_ADD, 32'h0, 16'h0, 16'h1234, 16'h0), 1,
                mk_result(STATUS_OK, 0, 16'h1234, 1, 0, 0, 0, 0));
        add_row(mk_cmd(CMD_ESTABLISH, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'h0), 1,
                mk_result(STATUS_OK, 1, 16'hFFFF, 1, 0, 0, 0, 0));
        // One short of the limit, then exactly at it: highest slot goes
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'd999), 0, none);
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'd1), 1,
                mk_result(STATUS_OK, 0, 0, 0, 1, 1, 32'hFFFF_FFFF, 16'hFFFF));
        add_row(mk_cmd(CMD_ESTABLISH, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'h0), 1,
                mk_result(STATUS_MISS, 0, 0, 0, 0, 0, 0, 0));
        // Fill the table, then one add too many
        for (int i = 1; i < SLOTS; i++)
            add_row(mk_cmd(CMD_ADD, 32'hC0A8_0000 + i, 16'(i), 16'(16'hA000 + i), 16'h0),
                    0, none);
        add_row(mk_cmd(CMD_ADD, 32'h0A00_0001, 16'd80, 16'h5555, 16'h0), 1,
                mk_result(STATUS_FULL, 0, 0, 0, 0, 0, 0, 0));
        // Saturate ages twice
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'hFFFF), 0, none);
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'hFFFF), 0, none);
        // Zero limit makes any live slot removable even with no time passed
        add_cfg_row(16'h0);
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'h0), 0, none);
        add_row(mk_cmd(CMD_CLEAR, 32'h0, 16'h0, 16'h0, 16'h0), 1, none);
        add_row(mk_cmd(CMD_ESTABLISH, 32'h0, 16'h0, 16'h0, 16'h0), 1,
                mk_result(STATUS_MISS, 0, 0, 0, 0, 0, 0, 0));
        // Top limit is reached only by a saturated age
        add_cfg_row(16'hFFFF);
        add_row(mk_cmd(CMD_ADD, 32'h0000_0005, 16'd7, 16'h0042, 16'h0), 0, none);
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'hFFFE), 0, none);
        add_row(mk_cmd(CMD_PRUNE, 32'h0, 16'h0, 16'h0, 16'hFFFF), 1,
                mk_result(STATUS_OK, 0, 0, 0, 1, 0, 32'h0000_0005, 16'd7));
    endfunction

    // Mostly pool keys so lookups and rewrites land; a few stray keys
    function automatic conn_cmd_t random_command();
        conn_cmd_t c;
        int        w;
        int        k;
        w = $urandom_range(0, 99);
        if (w < 36)
            c.op = CMD_ADD;
        else if (w < 66)
            c.op = CMD_ESTABLISH;
        else if (w < 96)
            c.op = CMD_PRUNE;
        else
            c.op = CMD_CLEAR;
        if ($urandom_range(0, 9) == 0)
        begin
            c.ip      = $urandom;
            c.l4_port = 16'($urandom);
        end
        else
        begin
            k         = $urandom_range(0, KEY_POOL - 1);
            c.ip      = pool_ip[k];
            c.l4_port = pool_port[k];
        end
        c.id = 16'($urandom);
        w    = $urandom_range(0, 9);
        if (w < 7)
            c.ms = 16'($urandom_range(0, 300));
        else if (w < 9)
            c.ms = 16'($urandom_range(0, 2000));
        else
            c.ms = 16'($urandom);
        return c;
    endfunction

    initial
    begin
        int          back_to_back;
        int          pick;
        logic [15:0] new_limit;
        conn_cmd_t   c;

        limit_shadow = STALE_LIMIT_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i]    = '0;
            tbl_port[i]  = '0;
            tbl_id[i]    = '0;
            tbl_age[i]   = '0;
            tbl_new[i]   = 1'b0;
        end
        // Half the pool shares an address with its neighbor, port differs
        for (int k = 0; k < KEY_POOL; k++)
        begin
            pool_ip[k]   = (k % 2 == 1) ? pool_ip[k - 1] : $urandom;
            pool_port[k] = 16'($urandom);
        end
        build_opening();
        back_to_back = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scripted opening, limit writes taken in order with the commands
        foreach (opening_rows[i])
        begin
            if (opening_rows[i].is_cfg)
                write_stale_limit(opening_rows[i].cfg_val);
            else
            begin
                maybe_idle(1'b1);
                send_command(opening_rows[i].item, opening_rows[i].typed,
                             opening_rows[i].want);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // New phase: new limit, new idling mix (zero gives clean stretches)
            if (n % PHASE_ITEMS == 0)
            begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: new_limit = 16'd1;
                    1: new_limit = 16'hFFFF;
                    2: new_limit = STALE_LIMIT_RESET;
                    default: new_limit = 16'($urandom_range(1, 4000));
                endcase
                write_stale_limit(new_limit);
                pick      = $urandom_range(0, 2);
                gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
                pick      = $urandom_range(0, 2);
                stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
            end
            // Long receiver hold while commands keep coming
            if (n == 400)
            begin
                hold_request = 1'b1;
                back_to_back = 14;
            end
            // Let everything come back before going on
            if (n == 550)
                wait_drained();
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            c = random_command();
            maybe_idle(back_to_back == 0);
            if (back_to_back > 0)
                back_to_back--;
            send_command(c, 1'b0, '0);
        end

        wait_drained();
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### connection_table_with_aging.f
hw/rtl/ctwa_pkg.sv
hw/rtl/ctwa_ram.sv
hw/rtl/ctwa_seq.sv
hw/rtl/connection_table_with_aging.sv
bench/tb_connection_table_with_aging.sv
